@@ rtl/mssp_pkg.sv @@
// Shared types and constants for the multi-source shortest path block.
// No dependencies; every other source file uses this package.
package mssp_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int MAX_DEGREE = 16;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int CNT_W      = NODE_W + 1;
	localparam int SLOT_W     = $clog2(MAX_DEGREE);
	localparam int DEG_W      = SLOT_W + 1;
	localparam int EDGE_AW    = NODE_W + SLOT_W;
	localparam int EDGES      = MAX_NODES * MAX_DEGREE;
	localparam int TIME_W     = 32;

	localparam logic [TIME_W-1:0] TIME_INF = 32'hFFFF_FFFF;
	localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFE;
	localparam logic [CNT_W-1:0]  NODE_CNT_RESET = CNT_W'(MAX_NODES);
	localparam logic [CNT_W-1:0]  LAST_NODE      = CNT_W'(MAX_NODES - 1);
	localparam logic [DEG_W-1:0]  DEG_FULL       = DEG_W'(MAX_DEGREE);

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_EDGE  = 3'd1,
		OP_ROOT  = 3'd2,
		OP_SOLVE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_NODE = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_EDGE,
		S_ROOT,
		S_READ,
		S_SCLR,
		S_SCAN0,
		S_SCAN,
		S_FINAL,
		S_DEG,
		S_E_RD,
		S_E_V,
		S_RELAX,
		S_RESP
	} state_t;

	typedef struct packed {
		logic saturate;
	} alu_ctl_t;

endpackage

@@ rtl/mssp_if.sv @@
// Valid/ready channel interfaces: request, response and config write.
// Depends on mssp_pkg for widths.
interface mssp_in_if;
	logic                         valid;
	logic                         ready;
	logic [2:0]                   operation;
	logic [mssp_pkg::NODE_W-1:0]  node;
	logic [mssp_pkg::NODE_W-1:0]  neighbor;
	logic [mssp_pkg::TIME_W-1:0]  value;
	modport source (output valid, operation, node, neighbor, value, input ready);
	modport sink (input valid, operation, node, neighbor, value, output ready);
endinterface

interface mssp_out_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [mssp_pkg::TIME_W-1:0]  arrival_time;
	logic                         reached;
	modport source (output valid, status, arrival_time, reached, input ready);
	modport sink (input valid, status, arrival_time, reached, output ready);
endinterface

interface mssp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mssp_pkg::CNT_W-1:0]   data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/mssp_alu.sv @@
// Shared adder, saturating when ctl.saturate is set, and compare used by root, scan and relax steps.
// Depends on mssp_pkg.
module mssp_alu (
	input  logic [31:0]        a,
	input  logic [31:0]        b,
	input  logic [31:0]        limit,
	input  mssp_pkg::alu_ctl_t ctl,
	output logic [31:0]        sum,
	output logic               lt
);
	import mssp_pkg::*;

	logic [TIME_W:0] raw;

	always_comb begin
		raw = {1'b0, a} + {1'b0, b};
		if (ctl.saturate && raw > {1'b0, TIME_MAX}) begin
			sum = TIME_MAX;
		end else begin
			sum = raw[TIME_W-1:0];
		end
		lt = sum < limit;
	end
endmodule

@@ rtl/multi_source_shortest_path.sv @@
// Top level: sequencer, graph memories and output register.
// Depends on mssp_pkg, mssp_if interfaces and mssp_alu.
//
//  channel | dir | fields
//  req     | in  | operation, node, neighbor, value
//  rsp     | out | status, arrival_time, reached
//  cfg     | in  | data = node_count
//
// Add edge, add root, read: the S_EDGE, S_ROOT or S_READ state, then the response beat.
// Clear: one node entry per cycle over all MAX_NODES entries; the same pass runs after reset.
// Solve: a pass over all nodes drops old results (S_SCLR), then per finalized node a
// scan (S_SCAN0, S_SCAN), the finalize steps (S_FINAL, S_DEG) and per edge S_E_RD, S_E_V
// and S_RELAX; a last scan that finds nothing ends it.
// req.ready is high only in idle; a waiting result holds the next one back.
module multi_source_shortest_path (
	input  logic       clk,
	input  logic       arst_n,
	mssp_in_if.sink    req,
	mssp_out_if.source rsp,
	mssp_cfg_if.sink   cfg
);
	import mssp_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  node_count_q;
	logic [CNT_W-1:0]  n_live;
	logic              from_item_q;

	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] nb_q;
	logic [TIME_W-1:0] val_q;
	logic [1:0]        status_q;
	logic [TIME_W-1:0] arr_q;
	logic              rch_q;
	logic [CNT_W-1:0]  idx_q;
	logic              pend_q;
	logic [NODE_W-1:0] pidx_q;
	logic [NODE_W-1:0] best_q;
	logic [TIME_W-1:0] best_t_q;
	logic              found_q;
	logic [DEG_W-1:0]  deg_q;
	logic [DEG_W-1:0]  k_q;
	logic [NODE_W-1:0] tgt_q;
	logic [TIME_W-1:0] w_q;

	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [TIME_W-1:0] rsp_arr_q;
	logic              rsp_rch_q;

	// memories
	logic [DEG_W-1:0]  deg_mem   [MAX_NODES];
	logic [TIME_W-1:0] tent_mem  [MAX_NODES];
	logic              fin_mem   [MAX_NODES];
	logic [TIME_W-1:0] ftime_mem [MAX_NODES];
	logic [NODE_W-1:0] etgt_mem  [EDGES];
	logic [TIME_W-1:0] ewgt_mem  [EDGES];

	logic [DEG_W-1:0]  deg_rd;
	logic [TIME_W-1:0] tent_rd;
	logic              fin_rd;
	logic [TIME_W-1:0] ftime_rd;
	logic [NODE_W-1:0] etgt_rd;
	logic [TIME_W-1:0] ewgt_rd;

	logic [NODE_W-1:0]  node_ra, node_wa;
	logic [EDGE_AW-1:0] edge_ra, edge_wa;
	logic               deg_we, tent_we, fin_we, ftime_we, edge_we;
	logic [DEG_W-1:0]   deg_wd;
	logic [TIME_W-1:0]  tent_wd;
	logic               fin_wd;

	logic [TIME_W-1:0] alu_a, alu_b, alu_limit, alu_sum;
	logic              alu_lt;
	alu_ctl_t          alu_ctl;

	logic accept;
	logic req_ok;
	logic k_last;

	assign n_live    = (node_count_q > NODE_CNT_RESET) ? NODE_CNT_RESET : node_count_q;
	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign k_last    = (k_q + DEG_W'(1)) == deg_q;

	always_comb begin
		req_ok = ({1'b0, req.node} < n_live);
		if (op_t'(req.operation) == OP_EDGE) begin
			req_ok = req_ok && ({1'b0, req.neighbor} < n_live);
		end
	end

	mssp_alu u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.limit (alu_limit),
		.ctl   (alu_ctl),
		.sum   (alu_sum),
		.lt    (alu_lt)
	);

	always_comb begin
		state_d   = state_q;
		node_ra   = node_q;
		node_wa   = node_q;
		edge_ra   = {best_q, k_q[SLOT_W-1:0]};
		edge_wa   = {node_q, deg_rd[SLOT_W-1:0]};
		deg_we    = 1'b0;
		tent_we   = 1'b0;
		fin_we    = 1'b0;
		ftime_we  = 1'b0;
		edge_we   = 1'b0;
		deg_wd    = deg_rd + DEG_W'(1);
		tent_wd   = alu_sum;
		fin_wd    = 1'b0;
		alu_a     = val_q;
		alu_b     = '0;
		alu_limit = tent_rd;
		alu_ctl.saturate = 1'b1;

		unique case (state_q)
			S_CLR: begin
				node_wa = idx_q[NODE_W-1:0];
				deg_we  = 1'b1;
				deg_wd  = '0;
				tent_we = 1'b1;
				tent_wd = TIME_INF;
				fin_we  = 1'b1;
				if (idx_q == LAST_NODE) begin
					state_d = from_item_q ? S_RESP : S_IDLE;
				end
			end
			S_IDLE: begin
				node_ra = req.node;
				if (accept) begin
					if (!req_ok && (op_t'(req.operation) == OP_EDGE ||
							op_t'(req.operation) == OP_ROOT ||
							op_t'(req.operation) == OP_READ)) begin
						state_d = S_RESP;
					end else begin
						case (op_t'(req.operation))
							OP_CLEAR: state_d = S_CLR;
							OP_EDGE:  state_d = S_EDGE;
							OP_ROOT:  state_d = S_ROOT;
							OP_SOLVE: state_d = S_SCLR;
							OP_READ:  state_d = S_READ;
							default:  state_d = S_RESP;
						endcase
					end
				end
			end
			S_EDGE: begin
				if (deg_rd < DEG_FULL) begin
					deg_we  = 1'b1;
					edge_we = 1'b1;
				end
				state_d = S_RESP;
			end
			S_ROOT: begin
				tent_we = alu_lt;
				state_d = S_RESP;
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_SCLR: begin
				node_wa = idx_q[NODE_W-1:0];
				fin_we  = 1'b1;
				if (idx_q == LAST_NODE) begin
					state_d = S_SCAN0;
				end
			end
			S_SCAN0: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				node_ra   = idx_q[NODE_W-1:0];
				alu_a     = tent_rd;
				alu_limit = best_t_q;
				alu_ctl.saturate = 1'b0;
				if (idx_q == n_live && !pend_q) begin
					state_d = found_q ? S_FINAL : S_RESP;
				end
			end
			S_FINAL: begin
				node_ra  = best_q;
				node_wa  = best_q;
				fin_we   = 1'b1;
				fin_wd   = 1'b1;
				ftime_we = 1'b1;
				state_d  = S_DEG;
			end
			S_DEG: begin
				state_d = (deg_rd == '0) ? S_SCAN0 : S_E_RD;
			end
			S_E_RD: begin
				state_d = S_E_V;
			end
			S_E_V: begin
				node_ra = etgt_rd;
				state_d = S_RELAX;
			end
			S_RELAX: begin
				node_wa = tgt_q;
				alu_a   = best_t_q;
				alu_b   = w_q;
				tent_we = ({1'b0, tgt_q} < n_live) && !fin_rd && alu_lt;
				state_d = k_last ? S_SCAN0 : S_E_RD;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_CNT_RESET;
			from_item_q  <= 1'b0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			found_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				node_count_q <= cfg.data;
			end
			if (state_q == S_RESP && (!rsp_valid_q || rsp.ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR, S_SCLR: begin
					idx_q <= idx_q + CNT_W'(1);
				end
				S_IDLE: begin
					from_item_q <= 1'b1;
					idx_q       <= '0;
				end
				S_SCAN0: begin
					idx_q   <= '0;
					pend_q  <= 1'b0;
					found_q <= 1'b0;
				end
				S_SCAN: begin
					pend_q <= (idx_q != n_live);
					if (idx_q != n_live) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (pend_q && !fin_rd && alu_lt) begin
						found_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				node_q   <= req.node;
				val_q    <= req.value;
				arr_q    <= '0;
				rch_q    <= 1'b0;
				if (!req_ok && (op_t'(req.operation) == OP_EDGE ||
						op_t'(req.operation) == OP_ROOT ||
						op_t'(req.operation) == OP_READ)) begin
					status_q <= ST_BAD_NODE;
				end else begin
					status_q <= ST_OK;
				end
			end
			S_EDGE: begin
				if (deg_rd >= DEG_FULL) begin
					status_q <= ST_FULL;
				end
			end
			S_READ: begin
				if (fin_rd) begin
					arr_q <= ftime_rd;
					rch_q <= 1'b1;
				end
			end
			S_SCAN0: begin
				best_t_q <= TIME_INF;
			end
			S_SCAN: begin
				pidx_q <= idx_q[NODE_W-1:0];
				if (pend_q && !fin_rd && alu_lt) begin
					best_t_q <= tent_rd;
					best_q   <= pidx_q;
				end
			end
			S_FINAL: begin
				k_q <= '0;
			end
			S_DEG: begin
				deg_q <= (deg_rd > DEG_FULL) ? DEG_FULL : deg_rd;
			end
			S_E_V: begin
				tgt_q <= etgt_rd;
				w_q   <= ewgt_rd;
			end
			S_RELAX: begin
				k_q <= k_q + DEG_W'(1);
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_status_q <= status_q;
					rsp_arr_q    <= arr_q;
					rsp_rch_q    <= rch_q;
				end
			end
			default: ;
		endcase
	end

	// node-indexed memories
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[node_wa] <= deg_wd;
		end
		if (tent_we) begin
			tent_mem[node_wa] <= tent_wd;
		end
		if (fin_we) begin
			fin_mem[node_wa] <= fin_wd;
		end
		if (ftime_we) begin
			ftime_mem[node_wa] <= best_t_q;
		end
		deg_rd   <= deg_mem[node_ra];
		tent_rd  <= tent_mem[node_ra];
		fin_rd   <= fin_mem[node_ra];
		ftime_rd <= ftime_mem[node_ra];
	end

	// edge memories
	always_ff @(posedge clk) begin
		if (edge_we) begin
			etgt_mem[edge_wa] <= nb_q;
			ewgt_mem[edge_wa] <= val_q;
		end
		etgt_rd <= etgt_mem[edge_ra];
		ewgt_rd <= ewgt_mem[edge_ra];
	end

	// neighbor of the pending add-edge beat
	always_ff @(posedge clk) begin
		if (accept) begin
			nb_q <= req.neighbor;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.arrival_time = rsp_arr_q;
	assign rsp.reached      = rsp_rch_q;
endmodule

@@ verif/multi_source_shortest_path_test.sv @@
// Self-checking testbench for multi_source_shortest_path: directed and random graphs.
// Depends on mssp_pkg and the mssp_if interfaces; predicts every response in-house.
module multi_source_shortest_path_test;
	import mssp_pkg::*;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int ITEM_TARGET = 700;

	typedef struct {
		logic [1:0]        status;
		logic [TIME_W-1:0] arrival;
		logic              reached;
	} path_result_t;

	logic clk;
	logic arst_n;

	mssp_in_if  req ();
	mssp_out_if rsp ();
	mssp_cfg_if cfg ();

	multi_source_shortest_path dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// graph shadow
	logic [NODE_W-1:0] edge_dst [EDGES];
	logic [TIME_W-1:0] edge_cost [EDGES];
	int                out_degree [MAX_NODES];
	logic [TIME_W-1:0] best_time [MAX_NODES];
	bit                settled [MAX_NODES];
	logic [TIME_W-1:0] settled_time [MAX_NODES];
	int unsigned       node_limit;

	path_result_t expected_q [$];
	int           errors;
	int           items_sent;
	bit           calm;
	int           hold_left;

	function automatic int unsigned live_nodes();
		return (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
	endfunction

	function automatic logic [TIME_W-1:0] sat_sum(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			out_degree[i] = 0;
			best_time[i] = TIME_INF;
			settled[i] = 0;
			settled_time[i] = '0;
		end
	endfunction

	function automatic void settle_all();
		int unsigned n;
		int best;
		logic [TIME_W-1:0] best_t;
		logic [TIME_W-1:0] t;
		int slot;
		int v;
		n = live_nodes();
		for (int i = 0; i < MAX_NODES; i++) begin
			settled[i] = 0;
			settled_time[i] = '0;
		end
		while (1) begin
			best = -1;
			best_t = TIME_INF;
			for (int i = 0; i < n; i++)
				if (!settled[i] && best_time[i] < best_t) begin
					best_t = best_time[i];
					best = i;
				end
			if (best < 0)
				break;
			settled[best] = 1;
			settled_time[best] = best_t;
			for (int k = 0; k < out_degree[best]; k++) begin
				slot = best * MAX_DEGREE + k;
				v = edge_dst[slot];
				if (v < n && !settled[v]) begin
					t = sat_sum(best_t, edge_cost[slot]);
					if (t < best_time[v])
						best_time[v] = t;
				end
			end
		end
	endfunction

	function automatic path_result_t path_step(logic [2:0] op, int node, int nb,
			logic [TIME_W-1:0] val);
		path_result_t r;
		int unsigned n;
		logic [TIME_W-1:0] t;
		n = live_nodes();
		r.status = ST_OK;
		r.arrival = '0;
		r.reached = 1'b0;
		case (op)
			OP_CLEAR: begin
				wipe_graph();
			end
			OP_EDGE: begin
				if (node >= n || nb >= n)
					r.status = ST_BAD_NODE;
				else if (out_degree[node] >= MAX_DEGREE)
					r.status = ST_FULL;
				else begin
					edge_dst[node * MAX_DEGREE + out_degree[node]] = NODE_W'(nb);
					edge_cost[node * MAX_DEGREE + out_degree[node]] = val;
					out_degree[node]++;
				end
			end
			OP_ROOT: begin
				if (node >= n)
					r.status = ST_BAD_NODE;
				else begin
					t = (val > TIME_MAX) ? TIME_MAX : val;
					if (t < best_time[node])
						best_time[node] = t;
				end
			end
			OP_SOLVE: begin
				settle_all();
			end
			OP_READ: begin
				if (node >= n)
					r.status = ST_BAD_NODE;
				else if (settled[node]) begin
					r.arrival = settled_time[node];
					r.reached = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// clock and watchdog
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[multi_source_shortest_path] ERROR");
		$finish;
	end

	// response side: random stalls and occasional long holds, always ready when calm
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (calm)
				rsp.ready <= 1'b1;
			else begin
				if ($urandom_range(0, 199) == 0)
					hold_left = $urandom_range(10, 40);
				rsp.ready <= ($urandom_range(0, 99) < 75);
			end
		end
	end

	// response checker; ready and valid are stable at the falling edge
	always @(negedge clk) begin
		path_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat", rsp.status, 0);
			end else begin
				want = expected_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.arrival_time !== want.arrival)
					report_mismatch("arrival_time", rsp.arrival_time, want.arrival);
				if (rsp.reached !== want.reached)
					report_mismatch("reached", rsp.reached, want.reached);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic [2:0] op, int node, int nb, logic [TIME_W-1:0] val);
		int gap;
		bit hit;
		path_result_t want_r;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.node      <= node[NODE_W-1:0];
		req.neighbor  <= nb[NODE_W-1:0];
		req.value     <= val;
		do begin
			@(negedge clk);
			hit = req.ready;
			@(posedge clk);
		end while (!hit);
		want_r = path_step(op, node[NODE_W-1:0], nb[NODE_W-1:0], val);
		expected_q = {expected_q, want_r};
		if (op <= OP_READ)
			items_sent++;
	endtask

	task automatic drain();
		@(posedge clk);
		req.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_node_count(int unsigned count);
		bit hit;
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= count[CNT_W-1:0];
		do begin
			@(negedge clk);
			hit = cfg.ready;
			@(posedge clk);
		end while (!hit);
		cfg.valid <= 1'b0;
		node_limit = count & 11'h7FF;
	endtask

	function automatic int pick_node(int unsigned n);
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, n - 1);
		if (r < 95)
			return $urandom_range(0, MAX_NODES - 1);
		return (n < MAX_NODES) ? n : MAX_NODES - 1;
	endfunction

	function automatic logic [TIME_W-1:0] pick_cost();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 32'h30000);
		if (r < 80)
			return $urandom;
		if (r < 90)
			return '0;
		return (r < 95) ? TIME_MAX : TIME_INF;
	endfunction

	// full-size graph: saturation, duplicate roots, full lists, unused codes
	task automatic test_full_size_graph();
		send_item(OP_READ, MAX_NODES - 1, 0, '0);
		send_item(OP_ROOT, 0, 0, TIME_INF);
		send_item(OP_ROOT, 0, 0, 32'h5);
		send_item(OP_ROOT, 0, 0, 32'h9);
		send_item(OP_EDGE, 0, MAX_NODES - 1, TIME_MAX);
		send_item(OP_EDGE, MAX_NODES - 1, 1, 32'h0001_0000);
		send_item(OP_EDGE, 0, 2, 32'h0000_0000);
		send_item(OP_EDGE, 0, 2, 32'h0000_0003);
		for (int k = 0; k <= MAX_DEGREE; k++)
			send_item(OP_EDGE, 5, k, 32'h0000_0100);
		send_item(OP_SOLVE, 0, 0, '0);
		send_item(OP_READ, 0, 0, '0);
		send_item(OP_READ, MAX_NODES - 1, 0, '0);
		send_item(OP_READ, 1, 0, '0);
		send_item(OP_READ, 2, 0, '0);
		send_item(OP_READ, 5, 0, '0);
		send_item(3'd5, 3, 4, $urandom);
		send_item(3'd6, 3, 4, $urandom);
		send_item(3'd7, 3, 4, $urandom);
		send_item(OP_CLEAR, 0, 0, '0);
		send_item(OP_READ, 0, 0, '0);
	endtask

	// node count at its extremes and out of range
	task automatic test_node_count_limits();
		set_node_count(0);
		send_item(OP_EDGE, 0, 0, 32'h10);
		send_item(OP_ROOT, 0, 0, 32'h10);
		send_item(OP_SOLVE, 0, 0, '0);
		send_item(OP_READ, 0, 0, '0);
		set_node_count(1);
		send_item(OP_EDGE, 0, 1, 32'h10);
		send_item(OP_EDGE, 1, 0, 32'h10);
		send_item(OP_EDGE, 0, 0, 32'h10);
		send_item(OP_ROOT, 0, 0, 32'h77);
		send_item(OP_SOLVE, 0, 0, '0);
		send_item(OP_READ, 0, 0, '0);
		send_item(OP_READ, 1, 0, '0);
		set_node_count(2047);
		send_item(OP_CLEAR, 0, 0, '0);
		send_item(OP_ROOT, MAX_NODES - 1, 0, 32'h42);
		send_item(OP_EDGE, MAX_NODES - 1, 3, 32'h1);
		send_item(OP_SOLVE, 0, 0, '0);
		send_item(OP_READ, MAX_NODES - 1, 0, '0);
		send_item(OP_READ, 3, 0, '0);
	endtask

	// edges and roots above a shrunk node count are skipped by solve
	task automatic test_shrunk_count();
		set_node_count(MAX_NODES);
		send_item(OP_CLEAR, 0, 0, '0);
		send_item(OP_ROOT, 1, 0, 32'h100);
		send_item(OP_ROOT, 20, 0, 32'h1);
		send_item(OP_EDGE, 1, 20, 32'h5);
		send_item(OP_EDGE, 1, 2, 32'h7);
		send_item(OP_EDGE, 20, 3, 32'h1);
		set_node_count(8);
		send_item(OP_SOLVE, 0, 0, '0);
		for (int i = 0; i < 5; i++)
			send_item(OP_READ, i, 0, '0);
		send_item(OP_READ, 20, 0, '0);
	endtask

	// receiver holds off long while requests keep coming
	task automatic test_backpressure();
		set_node_count(16);
		send_item(OP_CLEAR, 0, 0, '0);
		hold_left = 400;
		for (int i = 0; i < 20; i++)
			send_item(OP_ROOT, $urandom_range(0, 15), 0, $urandom_range(0, 32'hFFFF));
		send_item(OP_SOLVE, 0, 0, '0);
		for (int i = 0; i < 16; i++)
			send_item(OP_READ, i, 0, '0);
	endtask

	task automatic test_random_graphs();
		int unsigned n;
		int edges;
		int phase;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			calm = (phase % 4 == 3);
			n = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			set_node_count(n);
			send_item(OP_CLEAR, pick_node(n), pick_node(n), $urandom);
			for (int pass = 0; pass < 2; pass++) begin
				edges = $urandom_range(0, 3 * n);
				for (int e = 0; e < edges; e++) begin
					send_item(OP_EDGE, pick_node(n), pick_node(n), pick_cost());
					if ($urandom_range(0, 19) == 0)
						send_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
				end
				repeat ($urandom_range(1, 3))
					send_item(OP_ROOT, pick_node(n), pick_node(n), pick_cost());
				send_item(OP_SOLVE, $urandom, $urandom, $urandom);
				repeat ($urandom_range(3, 10))
					send_item(OP_READ, pick_node(n), $urandom, $urandom);
			end
			phase++;
		end
		calm = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = OP_CLEAR;
		req.node      = '0;
		req.neighbor  = '0;
		req.value     = '0;
		cfg.valid     = 1'b0;
		cfg.data      = '0;
		errors        = 0;
		items_sent    = 0;
		calm          = 0;
		hold_left     = 0;
		node_limit    = MAX_NODES;
		for (int i = 0; i < EDGES; i++) begin
			edge_dst[i] = '0;
			edge_cost[i] = '0;
		end
		wipe_graph();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_full_size_graph();
		test_node_count_limits();
		test_shrunk_count();
		test_backpressure();
		test_random_graphs();
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[multi_source_shortest_path] OK");
		else
			$display("[multi_source_shortest_path] ERROR");
		$finish;
	end

endmodule

@@ multi_source_shortest_path.f @@
rtl/mssp_pkg.sv
rtl/mssp_if.sv
rtl/mssp_alu.sv
rtl/multi_source_shortest_path.sv
verif/multi_source_shortest_path_test.sv
